### rtl/ps2_mouse_device_macros.svh
// Assertion macros shared by the mouse device RTL
`ifndef PS2_MOUSE_DEVICE_MACROS_SVH
`define PS2_MOUSE_DEVICE_MACROS_SVH
`ifndef SYNTH
`define PS2M_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PS2M_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PS2M_ASSERT(label, clk, rst_n, prop, msg)
`define PS2M_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### rtl/ps2m_pkg.sv
package ps2m_pkg;

  typedef enum logic [1:0] {
    ACT_HOST  = 2'd0,
    ACT_EVENT = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MODE_STREAM = 2'd0,
    MODE_REMOTE = 2'd1,
    MODE_WRAP   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_RES  = 2'd1,
    PEND_RATE = 2'd2
  } pend_e;

  localparam logic [7:0] ACK_BYTE = 8'hFA;
  localparam logic [7:0] ERR_BYTE = 8'hFC;
  localparam logic [7:0] BAT_BYTE = 8'hAA;

  localparam logic [7:0] CMD_SCALE_1 = 8'hE6;
  localparam logic [7:0] CMD_SCALE_2 = 8'hE7;
  localparam logic [7:0] CMD_SET_RES = 8'hE8;
  localparam logic [7:0] CMD_STATUS  = 8'hE9;
  localparam logic [7:0] CMD_STREAM  = 8'hEA;
  localparam logic [7:0] CMD_READ    = 8'hEB;
  localparam logic [7:0] CMD_UNWRAP  = 8'hEC;
  localparam logic [7:0] CMD_WRAP    = 8'hEE;
  localparam logic [7:0] CMD_REMOTE  = 8'hF0;
  localparam logic [7:0] CMD_GET_ID  = 8'hF2;
  localparam logic [7:0] CMD_SET_RATE = 8'hF3;
  localparam logic [7:0] CMD_ENABLE  = 8'hF4;
  localparam logic [7:0] CMD_DISABLE = 8'hF5;
  localparam logic [7:0] CMD_DEFAULTS = 8'hF6;
  localparam logic [7:0] CMD_RESEND  = 8'hFE;
  localparam logic [7:0] CMD_RESET   = 8'hFF;

  localparam logic [2:0] ID_WHEEL  = 3'd3;
  localparam logic [2:0] ID_FIVE   = 3'd4;

  localparam int unsigned MaxBytes = 5;

  // One answer: up to five bytes, byte 0 goes first
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               cnt;
  } resp_t;

  // Queue status seen by the top level and the back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [7:0] wheel_knock(input logic [1:0] i);
    case (i)
      2'd0: wheel_knock = 8'd200;
      2'd1: wheel_knock = 8'd100;
      default: wheel_knock = 8'd80;
    endcase
  endfunction

  function automatic logic [7:0] button_knock(input logic [1:0] i);
    case (i)
      2'd0: button_knock = 8'd200;
      2'd1: button_knock = 8'd200;
      default: button_knock = 8'd80;
    endcase
  endfunction

endpackage

### rtl/ps2m_front.sv
module ps2m_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        action_i,
  input  logic [7:0]        host_byte_i,
  input  logic [15:0]       pos_x_i,
  input  logic [15:0]       pos_y_i,
  input  logic [4:0]        buttons_i,
  input  logic              wheeled_i,
  input  logic [15:0]       wheel_delta_i,
  output logic              push_o,
  output ps2m_pkg::resp_t   resp_o
);
  import ps2m_pkg::*;

  mode_e       mode_q, mode_d, saved_q, saved_d;
  pend_e       pend_q, pend_d;
  logic        rep_q, rep_d, scale_q, scale_d, moved_q, moved_d;
  logic [7:0]  res_q, res_d, rate_q, rate_d, scroll_q, scroll_d;
  logic [2:0]  id_q, id_d;
  logic [1:0]  wk_q, wk_d, bk_q, bk_d;
  logic signed [15:0] dx_q, dx_d, dy_q, dy_d, px_q, px_d, py_q, py_d;
  logic [4:0]  btn_q, btn_d;
  logic [31:0] rep_pkt_q, rep_pkt_d;
  resp_t       resp;

  // Clamp a delta to nine bits: low byte, sign and overflow
  function automatic logic [9:0] clamp9(input logic signed [15:0] v);
    if (v > 16'sd255)       clamp9 = {1'b1, 1'b0, 8'hFF};
    else if (v < -16'sd256) clamp9 = {1'b1, 1'b1, 8'h00};
    else                    clamp9 = {1'b0, v[15], v[7:0]};
  endfunction

  function automatic logic signed [15:0] acc16(input logic signed [15:0] d,
                                               input logic signed [15:0] n,
                                               input logic signed [15:0] p);
    logic signed [17:0] s;
    s = {{2{d[15]}}, d} + ({{2{n[15]}}, n} - {{2{p[15]}}, p});
    if (s > 18'sd32767)       acc16 = 16'sh7FFF;
    else if (s < -18'sd32768) acc16 = 16'sh8000;
    else                      acc16 = s[15:0];
  endfunction

  // Work out the answer and the next state of one item
  always_comb begin
    logic [9:0]  cx, cy;
    logic [7:0]  ext, st, b;
    logic [31:0] pkt;
    logic        do_pkt, send;
    mode_d = mode_q; saved_d = saved_q; pend_d = pend_q; rep_d = rep_q;
    scale_d = scale_q; moved_d = moved_q; res_d = res_q; rate_d = rate_q;
    scroll_d = scroll_q; id_d = id_q; wk_d = wk_q; bk_d = bk_q;
    dx_d = dx_q; dy_d = dy_q; px_d = px_q; py_d = py_q; btn_d = btn_q;
    rep_pkt_d = rep_pkt_q;
    resp = '0;
    do_pkt = 1'b0;
    send = 1'b0;
    b = host_byte_i;
    cx = clamp9(dx_q);
    cy = clamp9(dy_q);
    ext = 8'h00;
    if (id_q == ID_FIVE) ext[5:4] = btn_q[4:3];
    if (id_q >= ID_WHEEL) ext[3:0] = scroll_q[3:0];
    pkt = {ext, cy[7:0], cx[7:0], cy[9], cx[9], cy[8], cx[8], 1'b1, btn_q[2:0]};
    st = {1'b0, mode_q == MODE_REMOTE, rep_q, scale_q, 1'b0, btn_q[0], btn_q[2], btn_q[1]};
    case (action_i)
      ACT_HOST: begin
        if (pend_q != PEND_NONE) begin
          resp.bytes[0] = ACK_BYTE; resp.cnt = 3'd1;
          if (pend_q == PEND_RES) res_d = b;
          else begin
            if (id_d == 3'd0 && wk_d != 2'd3) begin
              if (b == wheel_knock(wk_d)) begin
                wk_d = wk_d + 2'd1;
                if (wk_d == 2'd3) id_d = ID_WHEEL;
              end else wk_d = 2'd0;
            end
            if (id_d == ID_WHEEL && bk_d != 2'd3) begin
              if (b == button_knock(bk_d)) begin
                bk_d = bk_d + 2'd1;
                if (bk_d == 2'd3) id_d = ID_FIVE;
              end else bk_d = 2'd0;
            end
            rate_d = b;
          end
          pend_d = PEND_NONE;
        end else if (mode_q == MODE_WRAP && b != CMD_UNWRAP && b != CMD_RESET) begin
          resp.bytes[0] = b; resp.cnt = 3'd1;
        end else begin
          resp.bytes[0] = ACK_BYTE; resp.cnt = 3'd1;
          case (b)
            CMD_SCALE_1:  scale_d = 1'b0;
            CMD_SCALE_2:  scale_d = 1'b1;
            CMD_SET_RES:  pend_d = PEND_RES;
            CMD_SET_RATE: pend_d = PEND_RATE;
            CMD_STATUS: begin
              resp.bytes[1] = st; resp.bytes[2] = res_q; resp.bytes[3] = rate_q;
              resp.cnt = 3'd4;
            end
            CMD_STREAM: begin
              dx_d = '0; dy_d = '0; scroll_d = '0; mode_d = MODE_STREAM;
            end
            CMD_READ: begin do_pkt = 1'b1; send = 1'b1; end
            CMD_UNWRAP: begin
              if (mode_q == MODE_WRAP) begin
                dx_d = '0; dy_d = '0; scroll_d = '0; mode_d = saved_q;
              end else resp.bytes[0] = ERR_BYTE;
            end
            CMD_WRAP: begin
              if (mode_q != MODE_WRAP) saved_d = mode_q;
              dx_d = '0; dy_d = '0; scroll_d = '0; mode_d = MODE_WRAP;
            end
            CMD_REMOTE: begin
              dx_d = '0; dy_d = '0; scroll_d = '0; mode_d = MODE_REMOTE;
            end
            CMD_GET_ID: begin resp.bytes[1] = {5'd0, id_q}; resp.cnt = 3'd2; end
            CMD_ENABLE:  rep_d = 1'b1;
            CMD_DISABLE: rep_d = 1'b0;
            CMD_DEFAULTS: begin
              res_d = 8'd4; rate_d = 8'd100; scale_d = 1'b0; rep_d = 1'b0;
              dx_d = '0; dy_d = '0; scroll_d = '0;
            end
            CMD_RESEND: send = 1'b1;
            CMD_RESET: begin
              res_d = 8'd4; rate_d = 8'd100; scale_d = 1'b0; rep_d = 1'b0;
              dx_d = '0; dy_d = '0; scroll_d = '0; mode_d = MODE_STREAM;
              id_d = 3'd0; wk_d = 2'd0; bk_d = 2'd0; pend_d = PEND_NONE;
              resp.bytes[1] = BAT_BYTE; resp.bytes[2] = 8'h00; resp.cnt = 3'd3;
            end
            default: resp.bytes[0] = ERR_BYTE;
          endcase
        end
      end
      ACT_EVENT: begin
        dx_d = acc16(dx_q, pos_x_i, px_q);
        dy_d = acc16(dy_q, pos_y_i, py_q);
        px_d = pos_x_i; py_d = pos_y_i;
        btn_d = buttons_i;
        if (wheeled_i) scroll_d = scroll_q + wheel_delta_i[7:0];
        moved_d = 1'b1;
      end
      ACT_TICK: begin
        if (mode_q == MODE_STREAM && rep_q && moved_q) begin
          do_pkt = 1'b1; send = 1'b1; moved_d = 1'b0;
        end
      end
      default: ;
    endcase
    // Build a fresh packet and/or replay the stored one
    if (do_pkt) begin
      rep_pkt_d = pkt; dx_d = '0; dy_d = '0; scroll_d = '0;
    end
    if (send) begin
      for (int i = 0; i < 4; i++) resp.bytes[resp.cnt + 3'(i)] = rep_pkt_d[8*i +: 8];
      resp.cnt = resp.cnt + ((id_q >= ID_WHEEL) ? 3'd4 : 3'd3);
    end
  end

  assign push_o = accept_i && (resp.cnt != 3'd0);
  assign resp_o = resp;

  // Hold device state, advance on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_STREAM; saved_q <= MODE_STREAM; pend_q <= PEND_NONE;
      rep_q <= 1'b0; scale_q <= 1'b0; moved_q <= 1'b0;
      res_q <= 8'd4; rate_q <= 8'd100; scroll_q <= '0; id_q <= '0;
      wk_q <= '0; bk_q <= '0; dx_q <= '0; dy_q <= '0; px_q <= '0; py_q <= '0;
      btn_q <= '0; rep_pkt_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d; saved_q <= saved_d; pend_q <= pend_d;
      rep_q <= rep_d; scale_q <= scale_d; moved_q <= moved_d;
      res_q <= res_d; rate_q <= rate_d; scroll_q <= scroll_d; id_q <= id_d;
      wk_q <= wk_d; bk_q <= bk_d; dx_q <= dx_d; dy_q <= dy_d; px_q <= px_d;
      py_q <= py_d; btn_q <= btn_d; rep_pkt_q <= rep_pkt_d;
    end
  end

endmodule

### rtl/ps2m_queue.sv
`include "ps2_mouse_device_macros.svh"
module ps2m_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ps2m_pkg::resp_t  push_data_i,
  input  logic             pop_i,
  output ps2m_pkg::resp_t  head_o,
  output ps2m_pkg::qstat_t stat_o
);
  import ps2m_pkg::*;

  resp_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;
  assign head_o = mem_q[rd_q];

  // Advance pointers and fill count
  always_comb begin
    wr_d = wr_q ^ push_i;
    rd_d = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  `PS2M_ASSERT(a_no_overfill, clk_i, rst_ni, cnt_q != 2'd3, "queue count out of range")
  `PS2M_ASSERT(a_push_room, clk_i, rst_ni, push_i |-> (cnt_q != 2'd2 || pop_i),
               "push into full queue")
  `PS2M_ASSERT(a_pop_data, clk_i, rst_ni, pop_i |-> cnt_q != 2'd0, "pop from empty queue")
  `PS2M_ASSERT(a_ptr_gap, clk_i, rst_ni, (wr_q ^ rd_q) == cnt_q[0], "pointers disagree with count")

endmodule

### rtl/ps2m_back.sv
`include "ps2_mouse_device_macros.svh"
module ps2m_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ps2m_pkg::resp_t  head_i,
  input  ps2m_pkg::qstat_t stat_i,
  output logic             pop_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast
);
  import ps2m_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       beat;

  assign m_axis_tvalid = !stat_i.empty;
  assign m_axis_tlast  = idx_q == head_i.cnt - 3'd1;
  assign beat  = m_axis_tvalid && m_axis_tready;
  assign pop_o = beat && m_axis_tlast;

  // Select the current byte of the head answer
  always_comb begin
    case (idx_q)
      3'd0: m_axis_tdata = head_i.bytes[0];
      3'd1: m_axis_tdata = head_i.bytes[1];
      3'd2: m_axis_tdata = head_i.bytes[2];
      3'd3: m_axis_tdata = head_i.bytes[3];
      3'd4: m_axis_tdata = head_i.bytes[4];
      default: m_axis_tdata = 8'h00;
    endcase
    idx_d = pop_o ? 3'd0 : (beat ? idx_q + 3'd1 : idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= 3'd0;
    else         idx_q <= idx_d;
  end

  `PS2M_ASSERT(a_idx_range, clk_i, rst_ni, m_axis_tvalid |-> idx_q < head_i.cnt,
               "byte index past answer length")
  `PS2M_ASSERT(a_idx_rest, clk_i, rst_ni, stat_i.empty |-> idx_q == 3'd0,
               "index left over with empty queue")
  `PS2M_ASSERT(a_pop_clear, clk_i, rst_ni, pop_o |=> idx_q == 3'd0,
               "index not cleared after last byte")

endmodule

### rtl/ps2_mouse_device.sv
// PS/2 mouse, device side, with wheel and five-button extensions.
// Input stream (s_axis): one beat per item. tuser carries the action
// (host byte, motion/button event, report tick); tdata carries the
// host byte, positions, buttons and wheel fields.
// Output stream (m_axis): bytes for the host, one per beat; tlast marks
// the final byte of the answer to one item. Items that cause no bytes
// produce no beats.
// The front decodes an item and updates all device state in the cycle it
// is accepted; its answer (up to five bytes) goes into a two-entry queue.
// The back sends queued bytes one per cycle while m_axis_tready is high;
// an answer is sent once it is registered in the queue and at its head.
// Throughput: one item per cycle while the queue has room; sustained rate
// is set by the byte sender, which sends 1 to 5 bytes per answer.
// When the receiver stalls, the queue fills and s_axis_tready drops;
// the payload on the output holds until taken.
// Reset puts the device in stream mode with reporting off, resolution 4,
// rate 100, ID 0, and empties the queue.
module ps2_mouse_device (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] host_byte, [23:8] pos_x, [39:24] pos_y, [44:40] buttons,
  // [45] wheeled, [61:46] wheel_delta, [63:62] zero
  input  logic [63:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);
  import ps2m_pkg::*;

  resp_t  resp, head;
  qstat_t stat;
  logic   accept, push, pop;

  assign s_axis_tready = !stat.full;
  assign accept = s_axis_tvalid && s_axis_tready;

  ps2m_front u_front (
    .clk_i, .rst_ni,
    .accept_i      (accept),
    .action_i      (s_axis_tuser),
    .host_byte_i   (s_axis_tdata[7:0]),
    .pos_x_i       (s_axis_tdata[23:8]),
    .pos_y_i       (s_axis_tdata[39:24]),
    .buttons_i     (s_axis_tdata[44:40]),
    .wheeled_i     (s_axis_tdata[45]),
    .wheel_delta_i (s_axis_tdata[61:46]),
    .push_o        (push),
    .resp_o        (resp)
  );

  ps2m_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (resp),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (stat)
  );

  ps2m_back u_back (
    .clk_i, .rst_ni,
    .head_i        (head),
    .stat_i        (stat),
    .pop_o         (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

endmodule
